FILE: rtl/sirt_pkg.sv
// shared constants and types for the signed integer to radix text unit
package sirt_pkg;

   localparam int DEFAULT_MAX_SYMBOLS = 16;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   localparam int CSR_DATA_W    = 64;
   localparam int CSR_IDX_W     = 2;
   localparam int LEN_W         = 5;
   localparam int CHAR_W        = 8;
   localparam int DIGIT_W       = 4;
   localparam int SYMS_PER_WORD = CSR_DATA_W / CHAR_W;

   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LEN     = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_SIGN,
      ST_READ,
      ST_EMIT
   } state_type;

endpackage

FILE: rtl/signed_int_to_radix_text_unit.sv
// signed integer to text converter with a programmable symbol set
// Each accepted value is written out as characters: a leading '-' for negative values, then
// the digits of the magnitude, most significant first, the final one flagged by rsp_is_last.
// With an invalid symbol set (fewer than two symbols, more than MAX_SYMBOLS, a NUL, '+' or
// '-' symbol, or a repeated symbol) a value is taken and produces no characters. Digits come
// from a shift-register long divider that retires four dividend bits per cycle; each finished
// division pushes one digit onto the digit stack. Each character then passes through a digit
// stack read and an output register load, and the sign through one output register load;
// output stalls hold the load. A new value is taken only once the last character of the
// previous one has been loaded into the output register. A configuration write while idle
// or scanning (re)starts a scan of all MAX_SYMBOLS symbol slots, one symbol per cycle unless
// another write restarts it; req_ready is low during the write and the scan.
module signed_int_to_radix_text_unit #(
   parameter int MAX_SYMBOLS = sirt_pkg::DEFAULT_MAX_SYMBOLS,
   parameter int VALUE_WIDTH = sirt_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [VALUE_WIDTH-1:0]       req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sirt_pkg::CHAR_W-1:0]         rsp_symbol_char,
   output logic                                rsp_is_last,
   input  logic                                csr_wr_en,
   input  logic [sirt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sirt_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int DW        = sirt_pkg::DIGIT_W;
   localparam int CW        = sirt_pkg::CHAR_W;
   localparam int LW        = sirt_pkg::LEN_W;
   localparam int STEPS     = (VALUE_WIDTH + DW - 1) / DW;
   localparam int PAD_W     = STEPS * DW;
   localparam int STEP_W    = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int IDX_W     = $clog2(VALUE_WIDTH);
   localparam int CNT_W     = $clog2(VALUE_WIDTH + 1);
   localparam int SYM_IDX_W = $clog2(MAX_SYMBOLS);

   sirt_pkg::state_type state_ff, state_in;

   logic [MAX_SYMBOLS-1:0][CW-1:0] sym_ff, sym_in;
   logic [LW-1:0]        base_len_ff, base_len_in;
   logic                 base_ok_ff, base_ok_in;
   logic                 chk_ok_ff, chk_ok_in;
   logic [SYM_IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [PAD_W-1:0]     mag_ff, mag_in;
   logic [DW-1:0]        rem_ff, rem_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]        rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [DW-1:0]        stack_mem [VALUE_WIDTH];
   logic [DW-1:0]        rd_data_ff;
   logic                 wr_en, rd_en;
   logic [IDX_W-1:0]     wr_addr, rd_addr;

   logic [VALUE_WIDTH-1:0] value_bits, value_mag;
   logic [PAD_W-1:0]       div_mag;
   logic [DW-1:0]          div_rem;
   logic                   div_zero;
   logic                   out_free, out_load;
   logic                   range_ok, sym_bad;

   // magnitude of the incoming value; the most negative value wraps to 2^(w-1)
   assign value_bits = req_value;
   assign value_mag  = value_bits[VALUE_WIDTH-1] ? (~value_bits + VALUE_WIDTH'(1)) : value_bits;

   // four restoring division steps on the top nibble of the dividend
   always_comb begin
      logic [DW:0]   part;
      logic [DW-1:0] rem_w;
      logic [DW-1:0] qbits;
      rem_w = rem_ff;
      qbits = '0;
      for (int k = 0; k < DW; k++) begin
         part = {rem_w, mag_ff[PAD_W-1-k]};
         if (part >= base_len_ff) begin
            qbits[DW-1-k] = 1'b1;
            part = part - base_len_ff;
         end
         rem_w = part[DW-1:0];
      end
      div_rem  = rem_w;
      div_mag  = {mag_ff[PAD_W-DW-1:0], qbits};
      div_zero = (div_mag == '0);
   end

   // symbol set scan, one symbol against all later ones per cycle
   always_comb begin
      logic [CW-1:0] c;
      logic          in_use;
      logic          dup;
      c      = sym_ff[chk_idx_ff];
      in_use = (LW'(chk_idx_ff) < base_len_ff);
      dup    = 1'b0;
      for (int j = 0; j < MAX_SYMBOLS; j++) begin
         if ((j > int'(chk_idx_ff)) && (LW'(j) < base_len_ff) && (sym_ff[j] == c)) begin
            dup = 1'b1;
         end
      end
      sym_bad  = in_use && ((c == sirt_pkg::CHAR_NUL) || (c == sirt_pkg::CHAR_PLUS) ||
                            (c == sirt_pkg::CHAR_MINUS) || dup);
      range_ok = (base_len_ff >= LW'(2)) && (base_len_ff <= LW'(MAX_SYMBOLS));
   end

   // configuration registers
   always_comb begin
      sym_in      = sym_ff;
      base_len_in = base_len_ff;
      if (csr_wr_en) begin
         for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if ((i < sirt_pkg::SYMS_PER_WORD) && (csr_index == sirt_pkg::CSR_SYMBOLS_LOW)) begin
               sym_in[i] = csr_data[i*CW +: CW];
            end
            if ((i >= sirt_pkg::SYMS_PER_WORD) &&
                (csr_index == sirt_pkg::CSR_SYMBOLS_HIGH)) begin
               sym_in[i] = csr_data[(i % sirt_pkg::SYMS_PER_WORD)*CW +: CW];
            end
         end
         if (csr_index == sirt_pkg::CSR_BASE_LEN) begin
            base_len_in = csr_data[LW-1:0];
         end
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == sirt_pkg::ST_IDLE) && !csr_wr_en;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      base_ok_in  = base_ok_ff;
      chk_ok_in   = chk_ok_ff;
      chk_idx_in  = chk_idx_ff;
      mag_in      = mag_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      cnt_in      = cnt_ff;
      neg_in      = neg_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      out_load    = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = cnt_ff[IDX_W-1:0];
      rd_en       = 1'b0;
      rd_addr     = cnt_ff[IDX_W-1:0] - IDX_W'(1);

      case (state_ff)
         sirt_pkg::ST_IDLE: begin
            if (csr_wr_en) begin
               state_in   = sirt_pkg::ST_CHECK;
               chk_idx_in = '0;
            end else if (req_valid && base_ok_ff) begin
               state_in = sirt_pkg::ST_DIVIDE;
               neg_in   = value_bits[VALUE_WIDTH-1];
               mag_in   = PAD_W'(value_mag);
               rem_in   = '0;
               step_in  = '0;
               cnt_in   = '0;
            end
         end
         sirt_pkg::ST_CHECK: begin
            if (csr_wr_en) begin
               chk_idx_in = '0;
            end else begin
               chk_ok_in  = ((chk_idx_ff == '0) ? range_ok : chk_ok_ff) && !sym_bad;
               chk_idx_in = chk_idx_ff + SYM_IDX_W'(1);
               if (chk_idx_ff == SYM_IDX_W'(MAX_SYMBOLS - 1)) begin
                  base_ok_in = chk_ok_in;
                  state_in   = sirt_pkg::ST_IDLE;
               end
            end
         end
         sirt_pkg::ST_DIVIDE: begin
            mag_in  = div_mag;
            rem_in  = div_rem;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(STEPS - 1)) begin
               wr_en   = 1'b1;
               cnt_in  = cnt_ff + CNT_W'(1);
               rem_in  = '0;
               step_in = '0;
               if (div_zero) begin
                  state_in = neg_ff ? sirt_pkg::ST_SIGN : sirt_pkg::ST_READ;
               end
            end
         end
         sirt_pkg::ST_SIGN: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_char_in = sirt_pkg::CHAR_MINUS;
               rsp_last_in = 1'b0;
               state_in    = sirt_pkg::ST_READ;
            end
         end
         sirt_pkg::ST_READ: begin
            rd_en    = 1'b1;
            cnt_in   = cnt_ff - CNT_W'(1);
            state_in = sirt_pkg::ST_EMIT;
         end
         sirt_pkg::ST_EMIT: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_char_in = sym_ff[rd_data_ff[SYM_IDX_W-1:0]];
               rsp_last_in = (cnt_ff == '0);
               state_in    = (cnt_ff == '0) ? sirt_pkg::ST_IDLE : sirt_pkg::ST_READ;
            end
         end
         default: begin
            state_in = sirt_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sirt_pkg::ST_IDLE;
         sym_ff       <= '0;
         base_len_ff  <= '0;
         base_ok_ff   <= 1'b0;
         chk_ok_ff    <= 1'b0;
         chk_idx_ff   <= '0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sym_ff       <= sym_in;
         base_len_ff  <= base_len_in;
         base_ok_ff   <= base_ok_in;
         chk_ok_ff    <= chk_ok_in;
         chk_idx_ff   <= chk_idx_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // digit stack, least significant digit at the bottom
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= div_rem;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_symbol_char = rsp_char_ff;
   assign rsp_is_last     = rsp_last_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(VALUE_WIDTH))
      else $error("digit count beyond stack depth");

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sirt_pkg::ST_DIVIDE) |-> ({1'b0, rem_ff} < base_len_ff))
      else $error("partial remainder not below radix");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register loaded while a transfer is pending");

   a_invalid_base_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !csr_wr_en && !base_ok_ff) |=>
         (state_ff == sirt_pkg::ST_IDLE) && !(rsp_valid_ff && !$past(rsp_valid_ff)))
      else $error("value with invalid symbol set started a conversion");

endmodule
